// ----- rtl/mgac_pkg.sv -----
// Package for the metric grid accent classifier.
// Holds the grid class codes, fixed field widths and the accent table.
// Depends on nothing.
package mgac_pkg;

    // Grid classes as they appear on the result stream
    localparam logic [2:0] GC_DOWN         = 3'd0;
    localparam logic [2:0] GC_BEAT         = 3'd1;
    localparam logic [2:0] GC_EIGHTH       = 3'd2;
    localparam logic [2:0] GC_SIXTEENTH    = 3'd3;
    localparam logic [2:0] GC_TRIPLET      = 3'd4;
    localparam logic [2:0] GC_THIRTYSECOND = 3'd5;
    localparam logic [2:0] GC_OFFGRID      = 3'd6;

    // Position field width and scaled magnitude width (41 bit difference << 6)
    localparam int POS_W        = 40;
    localparam int MAG_W        = 48;
    localparam int STEPS_PER_ST = 4;
    localparam int DIV_STAGES   = MAG_W / STEPS_PER_ST;
    localparam int NUM_GROUPS   = 6;
    localparam logic [2:0] MAX_DEN_LOG2 = 3'd6;

    typedef logic signed [4:0] t_accent;

    // Accent at full strength per drum group and grid class; invalid group gives 0
    function automatic t_accent accent_lookup(input logic [2:0] grp, input logic [2:0] cls);
        t_accent a;
        a = 5'sd0;
        case (grp)
            3'd0: case (cls)
                GC_DOWN: a = 5'sd8;   GC_BEAT: a = 5'sd5;    GC_EIGHTH: a = -5'sd3;
                GC_SIXTEENTH: a = -5'sd8; GC_TRIPLET: a = -5'sd5;
                GC_THIRTYSECOND: a = -5'sd10; default: a = -5'sd4;
            endcase
            3'd1: case (cls)
                GC_DOWN: a = 5'sd5;   GC_BEAT: a = 5'sd6;    GC_EIGHTH: a = -5'sd4;
                GC_SIXTEENTH: a = -5'sd12; GC_TRIPLET: a = -5'sd8;
                GC_THIRTYSECOND: a = -5'sd14; default: a = -5'sd6;
            endcase
            3'd2: case (cls)
                GC_DOWN: a = 5'sd12;  GC_BEAT: a = 5'sd8;    GC_EIGHTH: a = -5'sd3;
                GC_SIXTEENTH: a = -5'sd12; GC_TRIPLET: a = -5'sd7;
                GC_THIRTYSECOND: a = t_accent'(-16); default: a = -5'sd5;
            endcase
            3'd3: case (cls)
                GC_DOWN: a = 5'sd6;   GC_BEAT: a = 5'sd5;    GC_EIGHTH: a = -5'sd2;
                GC_SIXTEENTH: a = -5'sd6; GC_TRIPLET: a = -5'sd4;
                GC_THIRTYSECOND: a = -5'sd8; default: a = -5'sd3;
            endcase
            3'd4: case (cls)
                GC_DOWN: a = 5'sd8;   GC_BEAT: a = 5'sd4;    GC_EIGHTH: a = -5'sd2;
                GC_SIXTEENTH: a = -5'sd4; GC_TRIPLET: a = -5'sd3;
                GC_THIRTYSECOND: a = -5'sd5; default: a = -5'sd2;
            endcase
            3'd5: case (cls)
                GC_DOWN: a = 5'sd6;   GC_BEAT: a = 5'sd4;    GC_EIGHTH: a = -5'sd2;
                GC_SIXTEENTH: a = -5'sd6; GC_TRIPLET: a = -5'sd4;
                GC_THIRTYSECOND: a = -5'sd8; default: a = -5'sd3;
            endcase
            default: a = 5'sd0;
        endcase
        return a;
    endfunction

endpackage

// ----- rtl/metric_grid_accent_classifier_core.sv -----
// Metric grid accent classifier, top level.
// Pipelined bar modulo, beat split, grid target match and accent lookup.
// Depends on mgac_pkg.
//
//  channel   dir  tdata                                   tuser
//  s_axis    in   note_position, bar_start, numerator,    bar_start_known, drum_group
//                 denominator log2
//  m_axis    out  accent_value                            grid_class
//
// One result per transfer in, 18 register stages; one item per cycle sustained
// while the output is not stalled.
// Most of the stages form the bar modulo: 48 restoring steps, four per stage.
// Reset (synchronous, active low) clears the stage valid bits only.
// Each stage holds while the one after it is full and stalled, so bubbles
// close up and nothing is lost or repeated.
module metric_grid_accent_classifier_core
    import mgac_pkg::*;
#(
    parameter int TICKS_PER_QUARTER = 1920
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [39:0] note_position, [79:40] bar_start, [85:80] meter_numerator,
    // [88:86] meter_denominator_log2, [95:89] zero
    input  logic [95:0] i_s_axis_tdata,
    // [0] bar_start_known, [3:1] drum_group
    input  logic [3:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [4:0] accent_value, [7:5] zero
    output logic [7:0]  o_m_axis_tdata,
    // [2:0] grid_class
    output logic [2:0]  o_m_axis_tuser
);

    localparam int Q4         = 4 * TICKS_PER_QUARTER;
    localparam int BARLEN_MAX = 63 * Q4;
    localparam int BL_W       = $clog2(BARLEN_MAX + 1);
    localparam int REM_W      = BL_W + 1;
    localparam int BEAT_MAX   = 3 * Q4;
    localparam int D_W        = $clog2(24 * BEAT_MAX + 1);
    localparam int CMP_W      = D_W + 7;
    localparam int NSTG       = DIV_STAGES + 6;
    localparam int S_FIX      = DIV_STAGES + 2;
    localparam int S_QUO      = DIV_STAGES + 3;
    localparam int S_HIT      = DIV_STAGES + 4;
    localparam int S_OUT      = DIV_STAGES + 5;

    // Stage valid bits and load enables
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] en;

    always_comb begin
        en[NSTG-1] = !r_vld[NSTG-1] || i_m_axis_tready;
        for (int i = NSTG - 2; i >= 0; i--) begin
            en[i] = !r_vld[i] || en[i+1];
        end
    end

    assign o_s_axis_tready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_s_axis_tvalid;
            end
            for (int i = 1; i < NSTG; i++) begin
                if (en[i]) begin
                    r_vld[i] <= r_vld[i-1];
                end
            end
        end
    end

    // Item side fields carried along the pipe
    logic [5:0] r_num [NSTG-1];
    logic       r_cmp [NSTG-1];
    logic [2:0] r_dl  [NSTG-1];
    logic [2:0] r_grp [NSTG-1];

    // Stage 0: clamp meter, take the relative position
    logic signed [POS_W:0] r_x;
    logic [5:0]            n_num;
    logic [2:0]            n_dl;
    logic signed [POS_W:0] n_x;

    always_comb begin
        n_num = (i_s_axis_tdata[85:80] == 6'd0) ? 6'd1 : i_s_axis_tdata[85:80];
        n_dl  = (i_s_axis_tdata[88:86] > MAX_DEN_LOG2) ? MAX_DEN_LOG2 : i_s_axis_tdata[88:86];
        if (i_s_axis_tuser[0]) begin
            n_x = $signed({i_s_axis_tdata[39], i_s_axis_tdata[39:0]})
                - $signed({i_s_axis_tdata[79], i_s_axis_tdata[79:40]});
        end else begin
            n_x = $signed({i_s_axis_tdata[39], i_s_axis_tdata[39:0]});
        end
    end

    // Compound meter: eighth or shorter beat, numerator a multiple of three from six up
    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_x      <= n_x;
            r_num[0] <= n_num;
            r_dl[0]  <= n_dl;
            r_grp[0] <= i_s_axis_tuser[3:1];
            r_cmp[0] <= (n_dl >= 3'd3)
                && (n_num inside {6'd6, 6'd9, 6'd12, 6'd15, 6'd18, 6'd21, 6'd24,
                                  6'd27, 6'd30, 6'd33, 6'd36, 6'd39, 6'd42, 6'd45,
                                  6'd48, 6'd51, 6'd54, 6'd57, 6'd60, 6'd63});
        end
    end

    // Stage 1: scale by 2^dl, split sign and magnitude, bar length
    logic [MAG_W-1:0]        r_mag [DIV_STAGES+1];
    logic [REM_W-1:0]        r_rem [DIV_STAGES+1];
    logic                    r_neg [S_FIX];
    logic [BL_W-1:0]         r_bl  [S_FIX];
    logic signed [MAG_W-1:0] scaled;

    assign scaled = $signed({{(MAG_W-POS_W-1){r_x[POS_W]}}, r_x}) <<< r_dl[0];

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_neg[1]   <= scaled[MAG_W-1];
            r_mag[0]   <= scaled[MAG_W-1] ? MAG_W'(-scaled) : MAG_W'(scaled);
            r_rem[0]   <= '0;
            r_bl[1]    <= BL_W'(r_num[0] * Q4);
            r_num[1]   <= r_num[0];
            r_dl[1]    <= r_dl[0];
            r_grp[1]   <= r_grp[0];
            r_cmp[1]   <= r_cmp[0];
        end
    end

    // Restoring remainder, four dividend bits per stage
    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        logic [REM_W-1:0] rem_n;
        logic [MAG_W-1:0] mag_n;

        always_comb begin
            rem_n = r_rem[g];
            mag_n = r_mag[g];
            for (int s = 0; s < STEPS_PER_ST; s++) begin
                rem_n = {rem_n[REM_W-2:0], mag_n[MAG_W-1]};
                mag_n = {mag_n[MAG_W-2:0], 1'b0};
                if (rem_n >= {1'b0, r_bl[g+1]}) begin
                    rem_n = rem_n - {1'b0, r_bl[g+1]};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (en[g+2]) begin
                r_rem[g+1] <= rem_n;
                r_mag[g+1] <= mag_n;
                r_neg[g+2] <= r_neg[g+1];
                r_bl[g+2]  <= r_bl[g+1];
                r_num[g+2] <= r_num[g+1];
                r_dl[g+2]  <= r_dl[g+1];
                r_grp[g+2] <= r_grp[g+1];
                r_cmp[g+2] <= r_cmp[g+1];
            end
        end
    end

    // Non-negative position in the bar
    logic [BL_W-1:0] r_pb;
    logic [BL_W-1:0] rem_fin;

    assign rem_fin = r_rem[DIV_STAGES][BL_W-1:0];

    always_ff @(posedge i_clk) begin
        if (en[S_FIX]) begin
            r_pb <= (r_neg[S_FIX-1] && rem_fin != '0) ? r_bl[S_FIX-1] - rem_fin : rem_fin;
            r_num[S_FIX] <= r_num[S_FIX-1];
            r_dl[S_FIX]  <= r_dl[S_FIX-1];
            r_grp[S_FIX] <= r_grp[S_FIX-1];
            r_cmp[S_FIX] <= r_cmp[S_FIX-1];
        end
    end

    // Beat index and position within the beat (six restoring steps)
    logic [BL_W-1:0] r_p;
    logic [5:0]      r_q;
    logic [BL_W+5:0] qr;
    logic [BL_W+5:0] beat_w;
    logic [5:0]      qn;

    assign beat_w = r_cmp[S_FIX] ? (BL_W+6)'(BEAT_MAX) : (BL_W+6)'(Q4);

    always_comb begin
        qr = (BL_W+6)'(r_pb);
        qn = '0;
        for (int i = 5; i >= 0; i--) begin
            if (qr >= (beat_w << i)) begin
                qr    = qr - (beat_w << i);
                qn[i] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[S_QUO]) begin
            r_p          <= qr[BL_W-1:0];
            r_q          <= qn;
            r_num[S_QUO] <= r_num[S_FIX];
            r_dl[S_QUO]  <= r_dl[S_FIX];
            r_grp[S_QUO] <= r_grp[S_FIX];
            r_cmp[S_QUO] <= r_cmp[S_FIX];
        end
    end

    // Grid target match: |24p - t*beat| against the tolerance, with wrap
    logic [CMP_W-1:0] beat_c;
    logic [CMP_W-1:0] lim;
    logic [CMP_W-1:0] p24;

    assign beat_c = r_cmp[S_QUO] ? CMP_W'(BEAT_MAX) : CMP_W'(Q4);
    assign lim    = CMP_W'(72 * TICKS_PER_QUARTER) << r_dl[S_QUO];
    assign p24    = CMP_W'(r_p) * CMP_W'(24);

    function automatic logic near(input logic [CMP_W-1:0] a, input logic [CMP_W-1:0] bt,
                                  input int t24, input logic [CMP_W-1:0] lm);
        logic [CMP_W-1:0] b;
        logic [CMP_W-1:0] d;
        logic [CMP_W-1:0] w;
        b = bt * CMP_W'(t24);
        d = (a >= b) ? a - b : b - a;
        w = bt * CMP_W'(24) - d;
        return (d * CMP_W'(100) < lm) || (w * CMP_W'(100) < lm);
    endfunction

    logic       r_h_beat, r_h_down, r_h_c8, r_h_c16, r_h_8, r_h_16, r_h_tr, r_h_32;
    logic [6:0] rnd;

    always_comb begin
        rnd = {1'b0, r_q} + ((CMP_W'(r_p) << 1) >= beat_c ? 7'd1 : 7'd0);
    end

    always_ff @(posedge i_clk) begin
        if (en[S_HIT]) begin
            r_h_beat <= near(p24, beat_c, 0, lim);
            r_h_down <= (rnd == 7'd0)
                || ((r_cmp[S_QUO] ? 9'(rnd) * 9'd3 : 9'(rnd)) == 9'(r_num[S_QUO]));
            r_h_c8   <= near(p24, beat_c, 8, lim) || near(p24, beat_c, 16, lim);
            r_h_c16  <= near(p24, beat_c, 4, lim) || near(p24, beat_c, 12, lim)
                     || near(p24, beat_c, 20, lim);
            r_h_8    <= near(p24, beat_c, 12, lim);
            r_h_16   <= near(p24, beat_c, 6, lim) || near(p24, beat_c, 18, lim);
            r_h_tr   <= near(p24, beat_c, 8, lim) || near(p24, beat_c, 16, lim);
            r_h_32   <= near(p24, beat_c, 3, lim) || near(p24, beat_c, 9, lim)
                     || near(p24, beat_c, 15, lim) || near(p24, beat_c, 21, lim);
            r_cmp[S_HIT] <= r_cmp[S_QUO];
            r_grp[S_HIT] <= r_grp[S_QUO];
            r_num[S_HIT] <= r_num[S_QUO];
            r_dl[S_HIT]  <= r_dl[S_QUO];
        end
    end

    // Class priority and accent lookup into the output register
    logic [2:0] n_cls;
    logic [2:0] r_cls;
    t_accent    r_acc;

    always_comb begin
        if (r_h_beat) begin
            n_cls = r_h_down ? GC_DOWN : GC_BEAT;
        end else if (r_cmp[S_HIT]) begin
            n_cls = r_h_c8 ? GC_EIGHTH : (r_h_c16 ? GC_SIXTEENTH : GC_OFFGRID);
        end else if (r_h_8) begin
            n_cls = GC_EIGHTH;
        end else if (r_h_16) begin
            n_cls = GC_SIXTEENTH;
        end else if (r_h_tr) begin
            n_cls = GC_TRIPLET;
        end else if (r_h_32) begin
            n_cls = GC_THIRTYSECOND;
        end else begin
            n_cls = GC_OFFGRID;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[S_OUT]) begin
            r_cls <= n_cls;
            r_acc <= accent_lookup(r_grp[S_HIT], n_cls);
        end
    end

    assign o_m_axis_tvalid = r_vld[S_OUT];
    assign o_m_axis_tdata  = {3'b000, r_acc};
    assign o_m_axis_tuser  = r_cls;

endmodule

// ----- dv/tb.sv -----
// Testbench for metric_grid_accent_classifier_core: directed and random notes,
// a scoreboard class that predicts grid class and accent, random stream stalls.
// Depends on mgac_pkg and the core RTL.
module tb;
    import mgac_pkg::*;

    localparam int QUARTER    = 1920;
    localparam int WATCH_MAX  = 3000;
    localparam int RAND_ITEMS = 900;
    localparam int CALM_FROM  = 780;

    typedef struct {
        logic [2:0]        cls;
        logic signed [4:0] acc;
    } t_grid_result;

    // Predicts grid class and accent for every input transfer, checks results in order
    class t_grid_scoreboard;
        t_grid_result pending_q[$];
        int errors;
        int checked;
        int class_hits[7];

        static function bit near_target(longint p, longint beat, longint t24, longint lim);
            longint d;
            longint w;
            d = 24 * p - t24 * beat;
            if (d < 0) d = -d;
            w = d - 24 * beat;
            if (w < 0) w = -w;
            return (d * 100 < lim) || (w * 100 < lim);
        endfunction

        static function logic signed [4:0] accent_of(logic [2:0] grp, logic [2:0] cls);
            int rom [6][7] = '{
                '{ 8, 5, -3,  -8, -5, -10, -4},
                '{ 5, 6, -4, -12, -8, -14, -6},
                '{12, 8, -3, -12, -7, -16, -5},
                '{ 6, 5, -2,  -6, -4,  -8, -3},
                '{ 8, 4, -2,  -4, -3,  -5, -2},
                '{ 6, 4, -2,  -6, -4,  -8, -3}};
            if (grp >= NUM_GROUPS) return 5'sd0;
            return 5'(rom[grp][cls]);
        endfunction

        function void note_input(logic [95:0] data, logic [3:0] user);
            longint pos, bar0, num, k, barlen, beat, scale, lim, diff, pb, p, bpb, idx;
            int dl;
            bit compound;
            t_grid_result r;
            pos  = longint'($signed(data[39:0]));
            bar0 = longint'($signed(data[79:40]));
            num  = data[85:80];
            dl   = data[88:86];
            if (num == 0) num = 1;
            if (dl > 6) dl = 6;
            compound = dl >= 3 && num >= 6 && (num % 3) == 0;
            k      = compound ? 3 : 1;
            barlen = num * 4 * QUARTER;
            beat   = k * 4 * QUARTER;
            scale  = longint'(1) << dl;
            lim    = 3 * QUARTER * scale * 24;
            diff   = (user[0] ? pos - bar0 : pos) * scale;
            pb     = diff % barlen;
            if (pb < 0) pb += barlen;
            p = pb % beat;
            if (near_target(p, beat, 0, lim)) begin
                bpb = num / k;
                if (bpb < 1) bpb = 1;
                idx = ((2 * pb + beat) / (2 * beat)) % bpb;
                r.cls = (idx == 0) ? GC_DOWN : GC_BEAT;
            end else if (compound) begin
                if (near_target(p, beat, 8, lim) || near_target(p, beat, 16, lim))
                    r.cls = GC_EIGHTH;
                else if (near_target(p, beat, 4, lim) || near_target(p, beat, 12, lim) ||
                         near_target(p, beat, 20, lim))
                    r.cls = GC_SIXTEENTH;
                else
                    r.cls = GC_OFFGRID;
            end else if (near_target(p, beat, 12, lim)) begin
                r.cls = GC_EIGHTH;
            end else if (near_target(p, beat, 6, lim) || near_target(p, beat, 18, lim)) begin
                r.cls = GC_SIXTEENTH;
            end else if (near_target(p, beat, 8, lim) || near_target(p, beat, 16, lim)) begin
                r.cls = GC_TRIPLET;
            end else if (near_target(p, beat, 3, lim) || near_target(p, beat, 9, lim) ||
                         near_target(p, beat, 15, lim) || near_target(p, beat, 21, lim)) begin
                r.cls = GC_THIRTYSECOND;
            end else begin
                r.cls = GC_OFFGRID;
            end
            r.acc = accent_of(user[3:1], r.cls);
            pending_q.push_back(r);
        endfunction

        function void check_result(logic [7:0] data, logic [2:0] user);
            t_grid_result r;
            if (pending_q.size() == 0) begin
                $display("%0t: result with nothing pending: accent %0d class %0d",
                         $time, $signed(data[4:0]), user);
                errors++;
                return;
            end
            r = pending_q.pop_front();
            checked++;
            class_hits[r.cls]++;
            if (user !== r.cls) begin
                $display("%0t: grid class expected %0d actual %0d", $time, r.cls, user);
                errors++;
            end
            if (data[4:0] !== r.acc) begin
                $display("%0t: accent expected %0d actual %0d", $time, r.acc,
                         $signed(data[4:0]));
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [95:0] i_s_axis_tdata = '0;
    logic [3:0]  i_s_axis_tuser = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [7:0]  o_m_axis_tdata;
    logic [2:0]  o_m_axis_tuser;

    t_grid_scoreboard sb = new();
    bit calm = 1'b0;
    int idle_cycles = 0;
    int sent = 0;

    metric_grid_accent_classifier_core i_dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Monitor both channels and the stall watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready)
                sb.note_input(i_s_axis_tdata, i_s_axis_tuser);
            if (o_m_axis_tvalid && i_m_axis_tready)
                sb.check_result(o_m_axis_tdata, o_m_axis_tuser);
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCH_MAX) begin
                $display("%0t: watchdog expired, %0d results pending", $time,
                         sb.pending_q.size());
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Receiver: ready in random bursts of stall and flow, always ready in the tail
    int rx_left = 0;
    always @(posedge i_clk) begin
        if (calm) begin
            i_m_axis_tready <= 1'b1;
        end else if (rx_left > 0) begin
            rx_left <= rx_left - 1;
        end else if ($urandom_range(0, 2) == 0) begin
            i_m_axis_tready <= 1'b0;
            rx_left <= $urandom_range(1, 19);
        end else begin
            i_m_axis_tready <= 1'b1;
            rx_left <= $urandom_range(1, 40);
        end
    end

    // One input transfer, with an optional idle burst ahead of it
    task automatic send_note(logic [39:0] pos, logic [39:0] bar0, bit known,
                             logic [5:0] num, logic [2:0] dl, logic [2:0] grp);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 19);
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {7'd0, dl, num, bar0, pos};
        i_s_axis_tuser  <= {grp, known};
        do @(posedge i_clk); while (!o_s_axis_tready);
        sent++;
    endtask

    // Note near a grid target of a random meter, with jitter around the tolerance
    task automatic send_near_grid();
        logic [5:0] num;
        logic [2:0] dl;
        longint bar0, beat_ticks, bar_ticks, off;
        int n, d, t24;
        bit known;
        num = $urandom_range(0, 7) == 0 ? 6'($urandom) : 6'($urandom_range(1, 12));
        dl  = $urandom_range(0, 7) == 0 ? 3'($urandom) : 3'($urandom_range(1, 4));
        n = (num == 0) ? 1 : num;
        d = (dl > 6) ? 6 : dl;
        beat_ticks = ((d >= 3 && n >= 6 && n % 3 == 0) ? 3 : 1) * 4 * QUARTER;
        beat_ticks = beat_ticks >> d;
        bar_ticks  = (n * 4 * QUARTER) >> d;
        t24 = $urandom_range(0, 23);
        off = $urandom_range(0, 40) * bar_ticks + $urandom_range(0, n) * beat_ticks
              + (t24 * beat_ticks) / 24;
        case ($urandom_range(0, 3))
            0: off += 0;
            1: off += longint'($urandom_range(0, 8)) - 4;
            default: off += longint'($urandom_range(0, 140)) - 70;
        endcase
        known = $urandom_range(0, 3) != 0;
        bar0 = $urandom_range(0, 1) ? longint'($signed(40'($urandom) << $urandom_range(0, 8)))
                                    : longint'($urandom_range(0, 100000)) - 50000;
        if (!$urandom_range(0, 3)) off = -off;
        send_note(40'(known ? bar0 + off : off), 40'(bar0), known, num, dl,
                  3'($urandom_range(0, 7)));
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: field extremes, every meter corner and grid class
        send_note(40'h7F_FFFF_FFFF, 40'h80_0000_0000, 1, 6'd4, 3'd2, 3'd0);
        send_note(40'h80_0000_0000, 40'h7F_FFFF_FFFF, 1, 6'd4, 3'd2, 3'd1);
        send_note(40'h80_0000_0000, 40'd0, 0, 6'd63, 3'd7, 3'd7);
        send_note(40'h7F_FFFF_FFFF, 40'd0, 0, 6'd0, 3'd0, 3'd6);
        send_note(40'd0, 40'd0, 1, 6'd0, 3'd0, 3'd2);
        send_note(40'd1920, 40'd0, 1, 6'd4, 3'd2, 3'd2);
        send_note(40'd960, 40'd0, 1, 6'd4, 3'd2, 3'd3);
        send_note(40'd480, 40'd0, 1, 6'd4, 3'd2, 3'd4);
        send_note(40'd640, 40'd0, 1, 6'd4, 3'd2, 3'd5);
        send_note(40'd240, 40'd0, 1, 6'd4, 3'd2, 3'd0);
        send_note(40'd300, 40'd0, 1, 6'd4, 3'd2, 3'd1);
        send_note(40'd1976, 40'd0, 1, 6'd4, 3'd2, 3'd2);
        send_note(40'd1978, 40'd0, 1, 6'd4, 3'd2, 3'd2);
        send_note(40'd960, 40'd0, 1, 6'd6, 3'd3, 3'd3);
        send_note(40'd480, 40'd0, 1, 6'd6, 3'd3, 3'd4);
        send_note(40'd1440, 40'd0, 1, 6'd12, 3'd6, 3'd5);
        send_note(-40'd100, 40'd500, 1, 6'd3, 3'd2, 3'd1);
        send_note(40'd959, 40'd0, 1, 6'd32, 3'd6, 3'd0);
        send_note(40'd7680, 40'd0, 0, 6'd9, 3'd7, 3'd3);
        send_note(40'd3840, 40'd0, 1, 6'd2, 3'd1, 3'd4);

        // Random: mostly notes near the grid, some raw noise
        for (int i = 0; i < RAND_ITEMS; i++) begin
            if (i == 300) begin
                i_s_axis_tvalid <= 1'b0;
                while (sb.pending_q.size() != 0) @(posedge i_clk);
            end
            if (i == CALM_FROM) calm = 1'b1;
            if ($urandom_range(0, 4) == 0)
                send_note(40'({$urandom, $urandom}), 40'({$urandom, $urandom}),
                          1'($urandom), 6'($urandom), 3'($urandom), 3'($urandom));
            else
                send_near_grid();
        end
        i_s_axis_tvalid <= 1'b0;

        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("Sent %0d notes, checked %0d results with stalls on both streams.",
                 sent, sb.checked);
        $display("Grid classes seen (downbeat..off-grid): %0d %0d %0d %0d %0d %0d %0d",
                 sb.class_hits[0], sb.class_hits[1], sb.class_hits[2], sb.class_hits[3],
                 sb.class_hits[4], sb.class_hits[5], sb.class_hits[6]);
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- metric_grid_accent_classifier_core.f -----
rtl/mgac_pkg.sv
rtl/metric_grid_accent_classifier_core.sv
dv/tb.sv
